### src/fochs_pkg.sv
// ----------------------------------------------------------------------------
// fochs_pkg
// Shared types, constants and register codes for the offset to BIOS address
// translator.
// ----------------------------------------------------------------------------
package fochs_pkg;

	localparam int SECTOR_BYTES  = 512;
	localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);
	localparam int MAX_CYLINDERS = 1024;
	localparam int LINEAR_MARK   = 64;

	localparam int OFS_W  = 31;
	localparam int BLK_W  = 31;
	localparam int Q_W    = OFS_W - SECTOR_SHIFT;
	localparam int SPB_W  = 4;
	localparam int PRD_W  = BLK_W + SPB_W;
	localparam int SEC_W  = PRD_W + 1;
	localparam int SPT_W  = 6;
	localparam int HEAD_W = 8;
	localparam int LIN_W  = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam int DIV_STEPS_DEF = 4;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_HOLE      = 3'd1,
		ST_BOOT      = 3'd2,
		ST_CYL_LIMIT = 3'd3,
		ST_MEDIA     = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPB    = 3'd0,
		REG_PSTART = 3'd1,
		REG_SPT    = 3'd2,
		REG_HEADS  = 3'd3,
		REG_CYLS   = 3'd4,
		REG_DRIVE  = 3'd5,
		REG_MODE   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [SPB_W-1:0]  spb;
		logic [30:0]       pstart;
		logic [SPT_W-1:0]  spt;
		logic [HEAD_W-1:0] heads;
		logic [15:0]       cyls;
		logic [7:0]        drive;
		logic [2:0]        mode;
	} cfg_t;

	typedef struct packed {
		status_t          st;
		logic [BLK_W-1:0] mapped;
		logic [Q_W-1:0]   q;
	} side1_t;

	typedef struct packed {
		status_t          st;
		logic [LIN_W-1:0] lin;
	} side2_t;

	typedef struct packed {
		status_t          st;
		logic [LIN_W-1:0] lin;
		logic [SPT_W-1:0] sr;
	} side3_t;

endpackage

### src/fochs_cfg.sv
// ----------------------------------------------------------------------------
// fochs_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module fochs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fochs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fochs_pkg::CFG_DATA_W-1:0] cfg_data,
	output fochs_pkg::cfg_t                  cfg
);
	import fochs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spb    <= SPB_W'(2);
			cfg_q.pstart <= '0;
			cfg_q.spt    <= SPT_W'(63);
			cfg_q.heads  <= HEAD_W'(255);
			cfg_q.cyls   <= '0;
			cfg_q.drive  <= 8'd128;
			cfg_q.mode   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SPB:    cfg_q.spb    <= cfg_data[SPB_W-1:0];
				REG_PSTART: cfg_q.pstart <= cfg_data[30:0];
				REG_SPT:    cfg_q.spt    <= cfg_data[SPT_W-1:0];
				REG_HEADS:  cfg_q.heads  <= cfg_data[HEAD_W-1:0];
				REG_CYLS:   cfg_q.cyls   <= cfg_data[15:0];
				REG_DRIVE:  cfg_q.drive  <= cfg_data[7:0];
				REG_MODE:   cfg_q.mode   <= cfg_data[2:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

endmodule

### src/fochs_div.sv
// ----------------------------------------------------------------------------
// fochs_div
// Pipelined unsigned restoring divider, K quotient bits per stage, with a
// sideband word that travels alongside each item.
// ----------------------------------------------------------------------------
module fochs_div #(
	parameter int DW = 36,
	parameter int VW = 6,
	parameter int K  = 4,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [DW-1:0] in_dividend,
	input  logic [VW-1:0] in_divisor,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [DW-1:0] out_quo,
	output logic [VW-1:0] out_rem,
	output logic [SW-1:0] out_side
);
	localparam int NSTG = (DW + K - 1) / K;
	localparam int PW   = NSTG * K;

	logic          vld_s  [NSTG];
	logic [PW-1:0] quo_s  [NSTG];
	logic [VW-1:0] rem_s  [NSTG];
	logic [VW-1:0] dvs_s  [NSTG];
	logic [SW-1:0] side_s [NSTG];

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		logic          vi;
		logic [PW-1:0] qi, qn;
		logic [VW-1:0] ri, rn, di;
		logic [SW-1:0] si;
		logic [VW:0]   rt;

		if (g == 0) begin : g_first
			assign vi = in_vld;
			assign qi = PW'(in_dividend);
			assign ri = '0;
			assign di = in_divisor;
			assign si = in_side;
		end else begin : g_next
			assign vi = vld_s[g-1];
			assign qi = quo_s[g-1];
			assign ri = rem_s[g-1];
			assign di = dvs_s[g-1];
			assign si = side_s[g-1];
		end

		always_comb begin
			qn = qi;
			rt = {1'b0, ri};
			for (int j = 0; j < K; j++) begin
				rt = {rt[VW-1:0], qn[PW-1]};
				qn = {qn[PW-2:0], 1'b0};
				if (rt >= {1'b0, di}) begin
					rt = rt - {1'b0, di};
					qn[0] = 1'b1;
				end
			end
			rn = rt[VW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			quo_s[g]  <= qn;
			rem_s[g]  <= rn;
			dvs_s[g]  <= di;
			side_s[g] <= si;
		end
	end

	assign out_vld  = vld_s[NSTG-1];
	assign out_quo  = quo_s[NSTG-1][DW-1:0];
	assign out_rem  = rem_s[NSTG-1];
	assign out_side = side_s[NSTG-1];

endmodule

### src/file_offset_to_bios_chs_address_core.sv
// ----------------------------------------------------------------------------
// file_offset_to_bios_chs_address_core
// Byte offset to BIOS disk address translator (linear or CHS packing).
// Throughput: one item per cycle, busy is never raised.
// Depth is set by the three pipelined dividers (block, track, head split).
// Reset clears all valid bits and loads the register defaults; results are
// strobed on done for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module file_offset_to_bios_chs_address_core #(
	parameter int DIV_STEPS = fochs_pkg::DIV_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [fochs_pkg::OFS_W-1:0]      byte_offset,
	input  logic [fochs_pkg::BLK_W-1:0]      mapped_block,
	output logic                             done,
	output logic [2:0]                       status,
	output logic [7:0]                       addr_drive,
	output logic [7:0]                       addr_sector,
	output logic [7:0]                       addr_track,
	output logic [7:0]                       addr_head,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fochs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fochs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fochs_pkg::*;

	localparam int NS1 = (Q_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NS2 = (SEC_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int LAT = 4 + NS1 + 2 * NS2;

	cfg_t cfg;
	logic [SPB_W-1:0]  spb_eff;
	logic [SPT_W-1:0]  spt_eff;
	logic [HEAD_W-1:0] heads_eff;

	fochs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign spb_eff   = (cfg.spb == '0)   ? SPB_W'(1)  : cfg.spb;
	assign spt_eff   = (cfg.spt == '0)   ? SPT_W'(1)  : cfg.spt;
	assign heads_eff = (cfg.heads == '0) ? HEAD_W'(1) : cfg.heads;

	assign busy = 1'b0;

	// entry stage
	logic   vld_s1;
	side1_t side_s1;
	status_t st_in;

	always_comb begin
		if (cfg.mode[2] && (byte_offset[OFS_W-1:SECTOR_SHIFT] != '0)) begin
			st_in = ST_BOOT;
		end else if (cfg.mode[1] && (mapped_block == '0)) begin
			st_in = ST_HOLE;
		end else begin
			st_in = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.st     <= st_in;
		side_s1.mapped <= mapped_block;
		side_s1.q      <= byte_offset[OFS_W-1:SECTOR_SHIFT];
	end

	// sector within the block
	logic             d1_vld;
	logic [Q_W-1:0]   d1_quo;
	logic [SPB_W-1:0] d1_rem;
	logic [$bits(side1_t)-1:0] d1_side_raw;
	side1_t           d1_side;

	fochs_div #(.DW(Q_W), .VW(SPB_W), .K(DIV_STEPS), .SW($bits(side1_t))) u_div_blk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (vld_s1),
		.in_dividend (side_s1.q),
		.in_divisor  (spb_eff),
		.in_side     (side_s1),
		.out_vld     (d1_vld),
		.out_quo     (d1_quo),
		.out_rem     (d1_rem),
		.out_side    (d1_side_raw)
	);

	assign d1_side = side1_t'(d1_side_raw);

	// absolute sector: mapped block times spb plus remainder (mode bit 1) or the sector index, then add partition start
	logic             vld_s3, vld_s4;
	status_t          st_s3, st_s4;
	logic [SEC_W-1:0] sum_s3, sector_s4;
	logic [PRD_W-1:0] prod;

	assign prod = PRD_W'(d1_side.mapped) * PRD_W'(spb_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= d1_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		st_s3     <= d1_side.st;
		sum_s3    <= cfg.mode[1] ? (SEC_W'(prod) + SEC_W'(d1_rem))
		                         : (SEC_W'(d1_side.q) + SEC_W'(d1_quo & '0));
		st_s4     <= st_s3;
		sector_s4 <= sum_s3 + SEC_W'(cfg.pstart);
	end

	// split by sectors per track
	side2_t           side_s4;
	logic             d2_vld;
	logic [SEC_W-1:0] d2_quo;
	logic [SPT_W-1:0] d2_rem;
	logic [$bits(side2_t)-1:0] d2_side_raw;
	side2_t           d2_side;
	side3_t           side3_in;

	assign side_s4.st  = st_s4;
	assign side_s4.lin = sector_s4[LIN_W-1:0];

	fochs_div #(.DW(SEC_W), .VW(SPT_W), .K(DIV_STEPS), .SW($bits(side2_t))) u_div_trk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (vld_s4),
		.in_dividend (sector_s4),
		.in_divisor  (spt_eff),
		.in_side     (side_s4),
		.out_vld     (d2_vld),
		.out_quo     (d2_quo),
		.out_rem     (d2_rem),
		.out_side    (d2_side_raw)
	);

	assign d2_side     = side2_t'(d2_side_raw);
	assign side3_in.st  = d2_side.st;
	assign side3_in.lin = d2_side.lin;
	assign side3_in.sr  = d2_rem;

	// split by heads
	logic              d3_vld;
	logic [SEC_W-1:0]  cyl;
	logic [HEAD_W-1:0] head;
	logic [$bits(side3_t)-1:0] d3_side_raw;
	side3_t            d3_side;

	fochs_div #(.DW(SEC_W), .VW(HEAD_W), .K(DIV_STEPS), .SW($bits(side3_t))) u_div_hd (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (d2_vld),
		.in_dividend (d2_quo),
		.in_divisor  (heads_eff),
		.in_side     (side3_in),
		.out_vld     (d3_vld),
		.out_quo     (cyl),
		.out_rem     (head),
		.out_side    (d3_side_raw)
	);

	assign d3_side = side3_t'(d3_side_raw);

	// checks and packing
	status_t    st_fin;
	logic [7:0] drv_n, sec_n, trk_n, hd_n;
	logic [SPT_W-1:0] sec1;

	assign sec1 = d3_side.sr + SPT_W'(1);

	always_comb begin
		st_fin = d3_side.st;
		if (st_fin == ST_OK && !cfg.mode[0]) begin
			if (cyl >= SEC_W'(MAX_CYLINDERS)) begin
				st_fin = ST_CYL_LIMIT;
			end else if (cfg.cyls != '0 && cyl >= SEC_W'(cfg.cyls)) begin
				st_fin = ST_MEDIA;
			end
		end
		drv_n = '0;
		sec_n = '0;
		trk_n = '0;
		hd_n  = '0;
		if (st_fin == ST_OK) begin
			if (cfg.mode[0]) begin
				drv_n = cfg.drive | 8'(LINEAR_MARK);
				sec_n = d3_side.lin[7:0];
				trk_n = d3_side.lin[15:8];
				hd_n  = d3_side.lin[23:16];
			end else begin
				drv_n = cfg.drive;
				sec_n = {cyl[9:8], sec1};
				trk_n = cyl[7:0];
				hd_n  = head;
			end
		end
	end

	logic    done_q;
	status_t status_q;
	logic [7:0] drive_q, sector_q, track_q, head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d3_vld;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= st_fin;
		drive_q  <= drv_n;
		sector_q <= sec_n;
		track_q  <= trk_n;
		head_q   <= hd_n;
	end

	assign done        = done_q;
	assign status      = status_q;
	assign addr_drive  = drive_q;
	assign addr_sector = sector_q;
	assign addr_track  = track_q;
	assign addr_head   = head_q;

`ifndef SYNTHESIS
	a_done_follows_start : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching item");

	a_error_zero_fields : assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |->
		(addr_drive == '0 && addr_sector == '0 && addr_track == '0 && addr_head == '0))
		else $error("error result with nonzero address");

	a_boot_offset : assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_BOOT) |->
		($past(byte_offset[OFS_W-1:SECTOR_SHIFT], LAT) != '0))
		else $error("boot error on an offset inside the first sector");
`endif

endmodule

### dv/file_offset_to_bios_chs_address_core_tb.sv
// ----------------------------------------------------------------------------
// file_offset_to_bios_chs_address_core_tb
// Drives byte offsets and mapped blocks through the address translator under
// a series of register settings (linear, CHS, file and boot modes, zero and
// full-scale geometry) and checks every strobed address against a predictor.
// ----------------------------------------------------------------------------
module file_offset_to_bios_chs_address_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fochs_pkg::*;

	typedef struct {
		status_t    st;
		logic [7:0] drive;
		logic [7:0] sector;
		logic [7:0] track;
		logic [7:0] head;
	} bios_addr_t;

	class addr_scoreboard;
		logic [63:0] spb, pstart, spt, heads, cyls, drive, mode;
		bios_addr_t  pending_addrs[$];
		int          errors;

		function new();
			spb = 2; pstart = 0; spt = 63; heads = 255;
			cyls = 0; drive = 128; mode = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SPB:    spb = 64'(val[3:0]);
				REG_PSTART: pstart = 64'(val[30:0]);
				REG_SPT:    spt = 64'(val[5:0]);
				REG_HEADS:  heads = 64'(val[7:0]);
				REG_CYLS:   cyls = 64'(val[15:0]);
				REG_DRIVE:  drive = 64'(val[7:0]);
				REG_MODE:   mode = 64'(val[2:0]);
				default: ;
			endcase
		endfunction

		function void note_item(logic [OFS_W-1:0] ofs, logic [BLK_W-1:0] blk);
			bios_addr_t  a;
			logic [63:0] q, bsz, blkno, sec, tsz, hsz, rest, cyl;
			a = '{ST_OK, 8'd0, 8'd0, 8'd0, 8'd0};
			q = 64'(ofs) / SECTOR_BYTES;
			bsz = (spb == 0) ? 64'd1 : spb;
			blkno = q / bsz;
			if (mode[2] && ofs >= SECTOR_BYTES) begin
				a.st = ST_BOOT;
			end else if (mode[1] && blk == 0) begin
				a.st = ST_HOLE;
			end else begin
				if (mode[1])
					blkno = 64'(blk);
				sec = blkno * bsz + q % bsz + pstart;
				if (mode[0]) begin
					a.drive = drive[7:0] | 8'(LINEAR_MARK);
					a.sector = sec[7:0];
					a.track = sec[15:8];
					a.head = sec[23:16];
				end else begin
					tsz = (spt == 0) ? 64'd1 : spt;
					hsz = (heads == 0) ? 64'd1 : heads;
					rest = sec / tsz;
					cyl = rest / hsz;
					if (cyl >= MAX_CYLINDERS) begin
						a.st = ST_CYL_LIMIT;
					end else if (cyls != 0 && cyl >= cyls) begin
						a.st = ST_MEDIA;
					end else begin
						a.drive = drive[7:0];
						a.sector = 8'(sec % tsz + 1) | {cyl[9:8], 6'd0};
						a.track = cyl[7:0];
						a.head = 8'(rest % hsz);
					end
				end
			end
			pending_addrs.push_back(a);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", msg);
		endtask

		task check_addr(logic [2:0] st, logic [7:0] d, logic [7:0] s,
				logic [7:0] t, logic [7:0] h);
			bios_addr_t e;
			if (pending_addrs.size() == 0) begin
				report("result with no item outstanding");
			end else begin
				e = pending_addrs.pop_front();
				if (st !== e.st)
					report($sformatf("status %0d, want %0d", st, e.st));
				if (d !== e.drive)
					report($sformatf("drive %02x, want %02x", d, e.drive));
				if (s !== e.sector)
					report($sformatf("sector %02x, want %02x", s, e.sector));
				if (t !== e.track)
					report($sformatf("track %02x, want %02x", t, e.track));
				if (h !== e.head)
					report($sformatf("head %02x, want %02x", h, e.head));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [OFS_W-1:0]      byte_offset;
	logic [BLK_W-1:0]      mapped_block;
	logic                  done;
	logic [2:0]            status;
	logic [7:0]            addr_drive;
	logic [7:0]            addr_sector;
	logic [7:0]            addr_track;
	logic [7:0]            addr_head;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	addr_scoreboard sb = new();
	int             quiet_cycles = 0;
	bit             no_gaps;

	file_offset_to_bios_chs_address_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.byte_offset(byte_offset), .mapped_block(mapped_block),
		.done(done), .status(status), .addr_drive(addr_drive),
		.addr_sector(addr_sector), .addr_track(addr_track),
		.addr_head(addr_head), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (start && !busy)
			sb.note_item(byte_offset, mapped_block);
		if (done)
			sb.check_addr(status, addr_drive, addr_sector, addr_track, addr_head);
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 4000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(logic [OFS_W-1:0] ofs, logic [BLK_W-1:0] blk);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		byte_offset <= ofs;
		mapped_block <= blk;
		@(posedge clk iff !busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_addrs.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk iff cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task automatic load_cfg(int spb, int ps, int spt, int hd, int cy, int dr, int md);
		drain();
		write_reg(REG_SPB, CFG_DATA_W'(spb));
		write_reg(REG_PSTART, CFG_DATA_W'(ps));
		write_reg(REG_SPT, CFG_DATA_W'(spt));
		write_reg(REG_HEADS, CFG_DATA_W'(hd));
		write_reg(REG_CYLS, CFG_DATA_W'(cy));
		write_reg(REG_DRIVE, CFG_DATA_W'(dr));
		write_reg(REG_MODE, CFG_DATA_W'(md));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_directed();
		send_item(0, 0);
		send_item(511, 1);
		send_item(512, 0);
		send_item(1023, 7);
		send_item(31'h7fffffff, 31'h7fffffff);
		send_item(31'h7fffffff, 0);
		send_item(31'h2aaaaaaa, 31'h55555555);
		send_item(31'h55555555, 31'h2aaaaaaa);
	endtask

	task automatic run_random(int n);
		int          r;
		logic [30:0] ofs, blk;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (r < 3)
				ofs = 31'($urandom_range(0, 1023));
			else if (r < 7)
				ofs = 31'($urandom_range(0, 1 << 22));
			else
				ofs = 31'($urandom);
			r = $urandom_range(0, 9);
			if (r < 1)
				blk = 0;
			else if (r < 7)
				blk = 31'($urandom_range(1, 200000));
			else
				blk = 31'($urandom);
			send_item(ofs, blk);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		byte_offset = '0;
		mapped_block = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SPB;
		cfg_data = '0;
		no_gaps = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		load_cfg(0, 31'h7fffffff, 0, 0, 0, 0, 7);
		run_directed();
		load_cfg(15, 0, 63, 255, 65535, 255, 2);
		run_directed();
		load_cfg(8, 100, 1, 1, 1, 3, 0);
		run_directed();
		run_random(60);

		for (int p = 0; p < 16; p++) begin
			if (p < 8)
				load_cfg($urandom_range(1, 8), $urandom_range(0, 5000),
					$urandom_range(1, 63), $urandom_range(1, 255),
					$urandom_range(0, 1100), $urandom_range(0, 255), p);
			else
				load_cfg($urandom_range(0, 15), 31'($urandom),
					$urandom_range(0, 63), $urandom_range(0, 255),
					$urandom_range(0, 65535), $urandom_range(0, 255),
					$urandom_range(0, 7));
			run_random(85);
		end

		drain();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
src/fochs_pkg.sv
src/fochs_cfg.sv
src/fochs_div.sv
src/file_offset_to_bios_chs_address_core.sv
dv/file_offset_to_bios_chs_address_core_tb.sv
